// ----- hw/rtl/scc_pkg.sv -----
// ----------------------------------------------------------------------------
// scc_pkg
// Shared constants and the CORDIC arctangent table for the coordinate converter.
// ----------------------------------------------------------------------------
`default_nettype none

package scc_pkg;

	localparam int COORD_W    = 32;
	localparam int ANG_W      = 33;
	localparam int SC_W       = 34;
	localparam int VEC_W      = 52;
	localparam int UNIT_FRAC  = 30;
	localparam int GUARD_BITS = 16;
	localparam int SAT_W      = 40;

	localparam logic ACT_TO_CART = 1'b0;
	localparam logic ACT_TO_SPH  = 1'b1;

	localparam logic signed [ANG_W-1:0] PI_Q      = 33'sd843314857;
	localparam logic signed [ANG_W-1:0] HALF_PI_Q = 33'sd421657428;
	localparam logic signed [ANG_W-1:0] TWO_PI_Q  = 33'sd1686629714;

	localparam logic [UNIT_FRAC-1:0] GAIN_Q30 = 30'd652032874;

	localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7fff_ffff;
	localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;

	// atan(2^-k), Q28
	function automatic logic signed [ANG_W-1:0] atan_q(input int k);
		case (k)
			0:       atan_q = 33'sd210828714;
			1:       atan_q = 33'sd124459457;
			2:       atan_q = 33'sd65760959;
			3:       atan_q = 33'sd33381290;
			4:       atan_q = 33'sd16755422;
			5:       atan_q = 33'sd8385879;
			6:       atan_q = 33'sd4193963;
			7:       atan_q = 33'sd2097109;
			8:       atan_q = 33'sd1048571;
			9:       atan_q = 33'sd524287;
			10:      atan_q = 33'sd262144;
			11:      atan_q = 33'sd131072;
			12:      atan_q = 33'sd65536;
			13:      atan_q = 33'sd32768;
			14:      atan_q = 33'sd16384;
			15:      atan_q = 33'sd8192;
			16:      atan_q = 33'sd4096;
			17:      atan_q = 33'sd2048;
			18:      atan_q = 33'sd1024;
			19:      atan_q = 33'sd512;
			20:      atan_q = 33'sd256;
			21:      atan_q = 33'sd128;
			22:      atan_q = 33'sd64;
			23:      atan_q = 33'sd32;
			24:      atan_q = 33'sd16;
			25:      atan_q = 33'sd8;
			26:      atan_q = 33'sd4;
			27:      atan_q = 33'sd2;
			28:      atan_q = 33'sd1;
			default: atan_q = '0;
		endcase
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/scc_sincos.sv -----
// ----------------------------------------------------------------------------
// scc_sincos
// Pipelined rotation CORDIC: angle reduction, then one iteration per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module scc_sincos #(
	parameter int STEPS = 24
) (
	input  logic                              clk,
	input  logic signed [scc_pkg::COORD_W-1:0] ang,
	output logic signed [scc_pkg::SC_W-1:0]    cos_val,
	output logic signed [scc_pkg::SC_W-1:0]    sin_val
);

	logic signed [scc_pkg::ANG_W-1:0] ang_x;
	logic signed [scc_pkg::ANG_W-1:0] z_s1;
	logic signed [scc_pkg::ANG_W-1:0] z_s2;

	logic signed [scc_pkg::SC_W-1:0]  x_s    [0:STEPS];
	logic signed [scc_pkg::SC_W-1:0]  y_s    [0:STEPS];
	logic signed [scc_pkg::ANG_W-1:0] z_s    [0:STEPS];
	logic                             flip_s [0:STEPS];

	assign ang_x = scc_pkg::ANG_W'(ang);

	always_ff @(posedge clk) begin
		if (ang_x >= scc_pkg::TWO_PI_Q) begin
			z_s1 <= ang_x - scc_pkg::TWO_PI_Q;
		end else if (ang_x <= -scc_pkg::TWO_PI_Q) begin
			z_s1 <= ang_x + scc_pkg::TWO_PI_Q;
		end else begin
			z_s1 <= ang_x;
		end

		if (z_s1 > scc_pkg::PI_Q) begin
			z_s2 <= z_s1 - scc_pkg::TWO_PI_Q;
		end else if (z_s1 < -scc_pkg::PI_Q) begin
			z_s2 <= z_s1 + scc_pkg::TWO_PI_Q;
		end else begin
			z_s2 <= z_s1;
		end

		// fold into the right half plane
		x_s[0] <= scc_pkg::SC_W'(scc_pkg::GAIN_Q30);
		y_s[0] <= '0;
		if (z_s2 > scc_pkg::HALF_PI_Q) begin
			z_s[0]    <= z_s2 - scc_pkg::PI_Q;
			flip_s[0] <= 1'b1;
		end else if (z_s2 < -scc_pkg::HALF_PI_Q) begin
			z_s[0]    <= z_s2 + scc_pkg::PI_Q;
			flip_s[0] <= 1'b1;
		end else begin
			z_s[0]    <= z_s2;
			flip_s[0] <= 1'b0;
		end

		cos_val <= flip_s[STEPS] ? -x_s[STEPS] : x_s[STEPS];
		sin_val <= flip_s[STEPS] ? -y_s[STEPS] : y_s[STEPS];
	end

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		localparam logic signed [scc_pkg::ANG_W-1:0] ATAN_K = scc_pkg::atan_q(i);
		always_ff @(posedge clk) begin
			flip_s[i+1] <= flip_s[i];
			if (!z_s[i][scc_pkg::ANG_W-1]) begin
				x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] - ATAN_K;
			end else begin
				x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] + ATAN_K;
			end
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/scc_polar.sv -----
// ----------------------------------------------------------------------------
// scc_polar
// Pipelined vectoring CORDIC with gain correction of the magnitude.
// ----------------------------------------------------------------------------
`default_nettype none

module scc_polar #(
	parameter int STEPS = 24
) (
	input  logic                              clk,
	input  logic signed [scc_pkg::VEC_W-1:0]  px,
	input  logic signed [scc_pkg::VEC_W-1:0]  py,
	output logic signed [scc_pkg::VEC_W-1:0]  mag,
	output logic signed [scc_pkg::ANG_W-1:0]  ang
);

	localparam int HI_W = scc_pkg::VEC_W - 1 - scc_pkg::UNIT_FRAC;
	localparam int PL_W = 2 * scc_pkg::UNIT_FRAC;

	logic signed [scc_pkg::VEC_W-1:0] x_s [0:STEPS];
	logic signed [scc_pkg::VEC_W-1:0] y_s [0:STEPS];
	logic signed [scc_pkg::ANG_W-1:0] z_s [0:STEPS];

	logic                             pos_g1;
	logic [HI_W+scc_pkg::UNIT_FRAC-1:0] ph_g1;
	logic [PL_W-1:0]                  pl_g1;
	logic signed [scc_pkg::ANG_W-1:0] z_g1;
	logic [PL_W:0]                    pl_rnd;
	logic [scc_pkg::VEC_W-1:0]        mag_sum;

	assign pl_rnd  = {1'b0, pl_g1} + ((PL_W+1)'(1) << (scc_pkg::UNIT_FRAC - 1));
	assign mag_sum = scc_pkg::VEC_W'(ph_g1) +
		scc_pkg::VEC_W'(pl_rnd[PL_W:scc_pkg::UNIT_FRAC]);

	always_ff @(posedge clk) begin
		if (px[scc_pkg::VEC_W-1]) begin
			x_s[0] <= -px;
			y_s[0] <= -py;
			z_s[0] <= py[scc_pkg::VEC_W-1] ? -scc_pkg::PI_Q : scc_pkg::PI_Q;
		end else begin
			x_s[0] <= px;
			y_s[0] <= py;
			z_s[0] <= '0;
		end

		pos_g1 <= !x_s[STEPS][scc_pkg::VEC_W-1] && (x_s[STEPS] != '0);
		ph_g1  <= x_s[STEPS][scc_pkg::VEC_W-2:scc_pkg::UNIT_FRAC] * scc_pkg::GAIN_Q30;
		pl_g1  <= x_s[STEPS][scc_pkg::UNIT_FRAC-1:0] * scc_pkg::GAIN_Q30;
		z_g1   <= z_s[STEPS];

		mag <= pos_g1 ? $signed(mag_sum) : '0;
		ang <= z_g1;
	end

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		localparam logic signed [scc_pkg::ANG_W-1:0] ATAN_K = scc_pkg::atan_q(i);
		always_ff @(posedge clk) begin
			if (y_s[i] == '0) begin
				x_s[i+1] <= x_s[i];
				y_s[i+1] <= y_s[i];
				z_s[i+1] <= z_s[i];
			end else if (y_s[i][scc_pkg::VEC_W-1]) begin
				x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] - ATAN_K;
			end else begin
				x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] + ATAN_K;
			end
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/spherical_cartesian_converter_core.sv -----
// The delay from start to done is set by the two chained vectoring pipelines.
// Throughput: one point per cycle once busy is low; every stage is registered and nothing stalls.
// The result strobe done lasts one cycle and cannot be held off.
// Reset clears the valid pipeline and done; busy is high in reset and drops at
// the first clock edge after it, low from then on.
// ----------------------------------------------------------------------------
// spherical_cartesian_converter_core
// Spherical <-> cartesian point conversion with CORDIC pipelines.
// ----------------------------------------------------------------------------
`default_nettype none

module spherical_cartesian_converter_core #(
	parameter int CORDIC_STEPS = 24
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic                               action,
	input  logic signed [scc_pkg::COORD_W-1:0] in_a,
	input  logic signed [scc_pkg::COORD_W-1:0] in_b,
	input  logic signed [scc_pkg::COORD_W-1:0] in_c,
	output logic                               done,
	output logic signed [scc_pkg::COORD_W-1:0] out_a,
	output logic signed [scc_pkg::COORD_W-1:0] out_b,
	output logic signed [scc_pkg::COORD_W-1:0] out_c,
	output logic                               saturated
);

	localparam int LAT_SC = CORDIC_STEPS + 4;
	localparam int LAT_P  = CORDIC_STEPS + 3;
	localparam int LAT_V  = 2 * LAT_P;
	localparam int LAT    = LAT_V + 1;
	localparam int RS_W   = 36;
	localparam int PROD_W = 72;

	typedef struct packed {
		logic vld;
		logic act;
	} ctl_t;

	typedef struct packed {
		logic signed [scc_pkg::SAT_W-1:0] x;
		logic signed [scc_pkg::SAT_W-1:0] y;
		logic signed [scc_pkg::SAT_W-1:0] z;
	} sph_t;

	typedef struct packed {
		logic                               clip;
		logic signed [scc_pkg::COORD_W-1:0] val;
	} sat_t;

	function automatic logic signed [scc_pkg::SAT_W-1:0] mul_unit(
		input logic signed [RS_W-1:0]         p,
		input logic signed [scc_pkg::SC_W-1:0] q
	);
		logic signed [PROD_W-1:0] prod;
		prod = PROD_W'(p) * PROD_W'(q);
		prod = prod + (PROD_W'(1) <<< (scc_pkg::UNIT_FRAC - 1));
		mul_unit = scc_pkg::SAT_W'(prod >>> scc_pkg::UNIT_FRAC);
	endfunction

	function automatic sat_t sat_coord(input logic signed [scc_pkg::SAT_W-1:0] v);
		sat_t r;
		if (v > scc_pkg::SAT_W'(scc_pkg::COORD_MAX)) begin
			r.clip = 1'b1;
			r.val  = scc_pkg::COORD_MAX;
		end else if (v < scc_pkg::SAT_W'(scc_pkg::COORD_MIN)) begin
			r.clip = 1'b1;
			r.val  = scc_pkg::COORD_MIN;
		end else begin
			r.clip = 1'b0;
			r.val  = scc_pkg::COORD_W'(v);
		end
		return r;
	endfunction

	logic accept;
	logic busy_q;

	ctl_t ctl_line_q [0:LAT_V-1];

	logic signed [scc_pkg::COORD_W-1:0] a_line_q   [0:LAT_SC-1];
	logic signed [scc_pkg::COORD_W-1:0] c_line_q   [0:LAT_P-1];
	logic signed [scc_pkg::ANG_W-1:0]   phi_line_q [0:LAT_P-1];
	sph_t                               sph_line_q [0:CORDIC_STEPS-1];

	logic signed [scc_pkg::SC_W-1:0] ct, st, cp, sp;
	logic signed [RS_W-1:0]          rs_s1;
	logic signed [RS_W-1:0]          rz_s1;
	logic signed [scc_pkg::SC_W-1:0] cp_s1, sp_s1;
	sph_t                            sph_s2;

	logic signed [scc_pkg::VEC_W-1:0] px1, py1, px2;
	logic signed [scc_pkg::VEC_W-1:0] m1, m2;
	logic signed [scc_pkg::ANG_W-1:0] phi1, th2;
	logic signed [scc_pkg::SAT_W-1:0] r_wide;

	sat_t sa, sb, sc;

	logic                               done_q;
	logic signed [scc_pkg::COORD_W-1:0] out_a_q, out_b_q, out_c_q;
	logic                               sat_q;

	assign accept = start && !busy_q;
	assign busy   = busy_q;

	// spherical to cartesian
	scc_sincos #(.STEPS(CORDIC_STEPS)) u_theta (
		.clk     (clk),
		.ang     (in_b),
		.cos_val (ct),
		.sin_val (st)
	);

	scc_sincos #(.STEPS(CORDIC_STEPS)) u_phi (
		.clk     (clk),
		.ang     (in_c),
		.cos_val (cp),
		.sin_val (sp)
	);

	always_ff @(posedge clk) begin
		a_line_q[0] <= in_a[scc_pkg::COORD_W-1] ? '0 : in_a;
		for (int j = 1; j < LAT_SC; j++) begin
			a_line_q[j] <= a_line_q[j-1];
		end

		rs_s1 <= RS_W'(mul_unit(RS_W'(a_line_q[LAT_SC-1]), st));
		rz_s1 <= RS_W'(mul_unit(RS_W'(a_line_q[LAT_SC-1]), ct));
		cp_s1 <= cp;
		sp_s1 <= sp;

		sph_s2.x <= mul_unit(rs_s1, cp_s1);
		sph_s2.y <= mul_unit(rs_s1, sp_s1);
		sph_s2.z <= scc_pkg::SAT_W'(rz_s1);

		sph_line_q[0] <= sph_s2;
		for (int j = 1; j < CORDIC_STEPS; j++) begin
			sph_line_q[j] <= sph_line_q[j-1];
		end
	end

	// cartesian to spherical
	assign px1 = scc_pkg::VEC_W'(in_a) <<< scc_pkg::GUARD_BITS;
	assign py1 = scc_pkg::VEC_W'(in_b) <<< scc_pkg::GUARD_BITS;
	assign px2 = scc_pkg::VEC_W'(c_line_q[LAT_P-1]) <<< scc_pkg::GUARD_BITS;

	scc_polar #(.STEPS(CORDIC_STEPS)) u_xy (
		.clk (clk),
		.px  (px1),
		.py  (py1),
		.mag (m1),
		.ang (phi1)
	);

	scc_polar #(.STEPS(CORDIC_STEPS)) u_rz (
		.clk (clk),
		.px  (px2),
		.py  (m1),
		.mag (m2),
		.ang (th2)
	);

	always_ff @(posedge clk) begin
		c_line_q[0]   <= in_c;
		phi_line_q[0] <= phi1;
		for (int j = 1; j < LAT_P; j++) begin
			c_line_q[j]   <= c_line_q[j-1];
			phi_line_q[j] <= phi_line_q[j-1];
		end
	end

	assign r_wide = scc_pkg::SAT_W'((m2 + (scc_pkg::VEC_W'(1) <<< (scc_pkg::GUARD_BITS - 1)))
		>>> scc_pkg::GUARD_BITS);

	// result select and clipping
	always_comb begin
		if (ctl_line_q[LAT_V-1].act == scc_pkg::ACT_TO_SPH) begin
			sa = sat_coord(r_wide);
			sb = sat_coord(scc_pkg::SAT_W'(th2));
			sc = sat_coord(scc_pkg::SAT_W'(phi_line_q[LAT_P-1]));
		end else begin
			sa = sat_coord(sph_line_q[CORDIC_STEPS-1].x);
			sb = sat_coord(sph_line_q[CORDIC_STEPS-1].y);
			sc = sat_coord(sph_line_q[CORDIC_STEPS-1].z);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			for (int j = 0; j < LAT_V; j++) begin
				ctl_line_q[j] <= '0;
			end
		end else begin
			busy_q        <= 1'b0;
			done_q        <= ctl_line_q[LAT_V-1].vld;
			ctl_line_q[0] <= '{vld: accept, act: action};
			for (int j = 1; j < LAT_V; j++) begin
				ctl_line_q[j] <= ctl_line_q[j-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_line_q[LAT_V-1].vld) begin
			out_a_q <= sa.val;
			out_b_q <= sb.val;
			out_c_q <= sc.val;
			sat_q   <= sa.clip || sb.clip || sc.clip;
		end
	end

	assign done      = done_q;
	assign out_a     = out_a_q;
	assign out_b     = out_b_q;
	assign out_c     = out_c_q;
	assign saturated = sat_q;

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("done without a matching accepted beat");

	assert property (@(posedge clk) disable iff (!arst_n)
		(done && saturated) |->
			(out_a == scc_pkg::COORD_MAX || out_a == scc_pkg::COORD_MIN ||
			 out_b == scc_pkg::COORD_MAX || out_b == scc_pkg::COORD_MIN ||
			 out_c == scc_pkg::COORD_MAX || out_c == scc_pkg::COORD_MIN))
		else $error("saturated flag without a clipped field");

	assert property (@(posedge clk) disable iff (!arst_n)
		!busy |=> !busy)
		else $error("busy reasserted after reset");
`endif

endmodule

`default_nettype wire
